/* rtl/q8bd_pkg.sv */
// q8bd_pkg: shared constants and fp32 product function for the q8 block dequantizer
// no dependencies
`default_nettype none
package q8bd_pkg;
    localparam int BLOCK_ELEMENTS = 32;
    localparam logic [5:0] LAST_POSITION = 6'(BLOCK_ELEMENTS + 1);
    localparam logic [10:0] BPR_RESET = 11'd96;
    localparam logic [10:0] BPR_MAX = 11'd1024;
    localparam logic [31:0] QNAN_BITS = 32'h7fc0_0000;
    localparam logic [7:0] EXP_BIAS_ADJ = 8'(127 - 15);

    typedef struct packed {
        logic block_end;
        logic row_end;
    } t_marks;

    // exact product of a half scale and a signed 8-bit code, as fp32 bits
    function automatic logic [31:0] product_bits(input logic [15:0] half,
                                                 input logic [7:0] code);
        logic        hsign;
        logic [4:0]  hexp;
        logic [9:0]  hfrac;
        logic        csign;
        logic [7:0]  cmag;
        logic        sign;
        logic [10:0] sig;
        logic [18:0] prod;
        logic [4:0]  k;
        logic [7:0]  biased;
        logic [41:0] shifted;
        logic [31:0] res;
        hsign = half[15];
        hexp  = half[14:10];
        hfrac = half[9:0];
        csign = code[7];
        cmag  = csign ? 8'(~code + 8'd1) : code;
        sign  = hsign ^ csign;
        sig   = (hexp == 5'd0) ? {1'b0, hfrac} : {1'b1, hfrac};
        prod  = 19'(sig * cmag);
        k = 5'd0;
        for (int i = 0; i < 19; i++) begin
            if (prod[i]) k = 5'(i);
        end
        // biased = k + exp - 25 + 127 (normal) or k - 24 + 127 (subnormal)
        biased = 8'(k) + ((hexp == 5'd0) ? 8'd103 : 8'(8'(hexp) + EXP_BIAS_ADJ - 8'd10));
        shifted = 42'(prod) << (5'd23 - k);
        if (hexp == 5'h1f) begin
            if (hfrac != 10'd0)
                res = {hsign, 8'hff, 1'b1, hfrac[8:0], 13'd0};
            else if (cmag == 8'd0)
                res = QNAN_BITS;
            else
                res = {sign, 8'hff, 23'd0};
        end else if (prod == 19'd0) begin
            res = {sign, 31'd0};
        end else begin
            res = {sign, biased, shifted[22:0]};
        end
        return res;
    endfunction
endpackage
`default_nettype wire

/* rtl/q8bd_parser.sv */
// q8bd_parser: byte position tracking, scale capture and block/row end marks
// depends on q8bd_pkg
`default_nettype none
module q8bd_parser import q8bd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_byte,
    output logic             o_is_code,
    output logic [15:0]      o_scale,
    output t_marks           o_marks
);
    logic [5:0]  r_pos, n_pos;
    logic [7:0]  r_low;
    logic [15:0] r_scale;
    logic [9:0]  r_blk, n_blk;
    logic [10:0] r_bpr;
    logic [10:0] count;
    logic        bend, rend;

    always_comb begin
        count = r_bpr;
        if (count == 11'd0) count = 11'd1;
        if (count > BPR_MAX) count = BPR_MAX;
        bend = (r_pos >= LAST_POSITION);
        rend = bend && ((11'(r_blk) + 11'd1) >= count);
        n_pos = bend ? 6'd0 : r_pos + 6'd1;
        n_blk = r_blk;
        if (bend) n_blk = rend ? 10'd0 : r_blk + 10'd1;
    end

    assign o_is_code = (r_pos > 6'd1);
    assign o_scale = r_scale;
    assign o_marks = '{block_end: bend, row_end: rend};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_low   <= '0;
            r_scale <= '0;
            r_blk   <= '0;
            r_bpr   <= BPR_RESET;
        end else begin
            if (i_cfg_we) r_bpr <= i_cfg_data;
            if (i_take) begin
                r_pos <= n_pos;
                if (r_pos == 6'd0) r_low <= i_byte;
                if (r_pos == 6'd1) r_scale <= {i_byte, r_low};
                if (o_is_code) r_blk <= n_blk;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/q8bd_mult.sv */
// q8bd_mult: product logic and output register with handshake
// depends on q8bd_pkg
`default_nettype none
module q8bd_mult import q8bd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire logic [15:0] i_scale,
    input  wire logic [7:0]  i_code,
    input  wire t_marks      i_marks,
    input  wire logic        i_stall,
    output logic             o_ready,
    output logic             o_valid,
    output logic [31:0]      o_value,
    output t_marks           o_marks
);
    logic [31:0] r_value;
    t_marks      r_marks;
    logic        r_valid;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_marks = r_marks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_value <= product_bits(i_scale, i_code);
            r_marks <= i_marks;
        end
    end
endmodule
`default_nettype wire

/* rtl/q8_block_dequantizer_unit.sv */
// q8_block_dequantizer_unit: top level of the q8 block dequantizer
// depends on q8bd_pkg, q8bd_parser, q8bd_mult
//   channel | signals                                   | dir
//   in      | i_valid, o_stall, i_data_byte             | in
//   out     | o_valid, i_stall, o_value_bits, marks     | out
//   cfg     | i_cfg_we, i_cfg_data (row length)         | in
// one byte accepted per cycle while o_stall is low; a code word appears in the cycle after it is taken,
// set by the single result register after the product logic
// scale bytes give no word; synchronous active-low reset clears position,
// block count and sets the row length to 96 blocks; o_stall rises only while the
// result register holds a word and i_stall is high
`default_nettype none
module q8_block_dequantizer_unit import q8bd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_value_bits,
    output logic             o_block_end,
    output logic             o_row_end,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_data
);
    logic        ready, take, is_code;
    logic [15:0] scale;
    t_marks      marks, out_marks;

    assign o_stall = !ready;
    assign take = i_valid && ready;

    q8bd_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_take(take), .i_byte(i_data_byte),
        .o_is_code(is_code), .o_scale(scale), .o_marks(marks)
    );

    q8bd_mult u_mult (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(take && is_code),
        .i_scale(scale), .i_code(i_data_byte), .i_marks(marks),
        .i_stall(i_stall), .o_ready(ready), .o_valid(o_valid),
        .o_value(o_value_bits), .o_marks(out_marks)
    );

    assign o_block_end = out_marks.block_end;
    assign o_row_end = out_marks.row_end;

`ifndef SYNTHESIS
    a_row_implies_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_row_end || o_block_end)) else $error("row end without block end");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_value_bits)))
        else $error("result changed under stall");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)) else $error("stall without full register");
`endif
endmodule
`default_nettype wire

/* tb/tb_q8_block_dequantizer_unit.sv */
// testbench for q8_block_dequantizer_unit: streams q8 blocks and checks every word
// against an in-bench fp32 product predictor; depends on q8bd_pkg and the rtl
`timescale 1ns / 100ps
module tb_q8_block_dequantizer_unit;
    import q8bd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_value_bits;
    logic        o_block_end;
    logic        o_row_end;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_data = 11'd0;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        block_end;
        logic        row_end;
    } t_word;

    t_word       words_due[$];
    logic [5:0]  pos_m;
    logic [7:0]  lo_m;
    logic [15:0] scale_m;
    logic [9:0]  blk_m;
    logic [10:0] bpr_m;
    int          fails = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    int          rx_gap = 0;

    q8_block_dequantizer_unit dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("q8_block_dequantizer_unit regression: fail");
            $finish;
        end
    end

    // expected fp32 bits of half scale times signed code
    function automatic logic [31:0] scaled_code(logic [15:0] h, logic [7:0] c);
        logic [4:0]  e;
        logic [9:0]  f;
        logic [7:0]  mag;
        logic        s;
        logic [18:0] p;
        int          msb;
        int          ex;
        logic [31:0] m;
        e = h[14:10];
        f = h[9:0];
        mag = c[7] ? 8'(-c) : c;
        s = h[15] ^ c[7];
        if (e == 5'h1f) begin
            if (f != 0) return {h[15], 8'hff, 1'b1, f[8:0], 13'd0};
            if (mag == 0) return 32'h7fc0_0000;
            return {s, 8'hff, 23'd0};
        end
        p = (e == 0 ? {9'd0, f} : {8'd0, 1'b1, f}) * mag;
        if (p == 0) return {s, 31'd0};
        ex = (e == 0) ? -24 : int'(e) - 25;
        msb = 0;
        for (int i = 0; i < 19; i++) if (p[i]) msb = i;
        m = 32'(p) << (23 - msb);
        return {s, 8'(msb + ex + 127), m[22:0]};
    endfunction

    // advance the predictor by one accepted byte
    task automatic predict_byte(input logic [7:0] b);
        t_word w;
        int    cnt;
        logic [5:0] p;
        p = pos_m;
        pos_m = (p >= 6'd33) ? 6'd0 : p + 6'd1;
        if (p == 0) begin
            lo_m = b;
        end else if (p == 1) begin
            scale_m = {b, lo_m};
        end else begin
            w.block_end = (p >= 6'd33);
            w.row_end = 1'b0;
            if (w.block_end) begin
                cnt = (bpr_m == 0) ? 1 : (bpr_m > 1024 ? 1024 : int'(bpr_m));
                if (int'(blk_m) + 1 >= cnt) begin
                    w.row_end = 1'b1;
                    blk_m = 0;
                end else begin
                    blk_m = blk_m + 10'd1;
                end
            end
            w.value_bits = scaled_code(scale_m, b);
            words_due = {words_due, w};
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_byte(b);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_row_len(input logic [10:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bpr_m = v;
    endtask

    task automatic send_block(input logic [15:0] sc, input int kind);
        send_byte(sc[7:0]);
        send_byte(sc[15:8]);
        for (int i = 0; i < 32; i++)
            send_byte(kind == 0 ? 8'($urandom) : 8'(i * 8 + kind));
    endtask

    // random half with a bias toward special exponents
    function automatic logic [15:0] pick_scale();
        logic [15:0] h;
        h = 16'($urandom);
        case ($urandom_range(0, 7))
            0: h[14:10] = 5'h1f;
            1: h[14:10] = 5'h00;
            default: ;
        endcase
        return h;
    endfunction

    task automatic test_special_scales();
        send_block(16'h3c00, 1);
        send_block(16'h7bff, 7);
        send_block(16'h8001, 0);
        send_block(16'h7c00, 0);
        send_block(16'hfc00, 2);
        send_block(16'h7e55, 3);
        send_block(16'hfd01, 0);
        send_block(16'h0000, 5);
        send_block(16'h8000, 0);
    endtask

    task automatic test_row_lengths();
        set_row_len(11'd1);
        send_block(16'h3c00, 0);
        set_row_len(11'd0);
        send_block(16'h4000, 0);
        set_row_len(11'd3);
        send_block(pick_scale(), 0);
        send_block(pick_scale(), 0);
        // shorten mid-row: row ends at the next block end
        set_row_len(11'd1);
        send_block(pick_scale(), 0);
        set_row_len(11'd2047);
        send_block(pick_scale(), 0);
        set_row_len(11'd1024);
        send_block(pick_scale(), 0);
    endtask

    task automatic test_random_stream();
        for (int n = 0; n < 24; n++) begin
            if (n == 10) drain();
            if (n == 14) set_row_len(11'($urandom_range(1, 4)));
            if (n == 18) quiet = 1'b1;
            send_block(pick_scale(), 0);
        end
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (words_due.size() == 0) begin
                $display("%0t unexpected word %h", $time, o_value_bits);
                fails++;
            end else begin
                w = words_due.pop_front();
                if (w != {o_value_bits, o_block_end, o_row_end}) begin
                    $display("%0t expected %h %b %b actual %h %b %b", $time,
                             w.value_bits, w.block_end, w.row_end,
                             o_value_bits, o_block_end, o_row_end);
                    fails++;
                end
            end
        end
        if (quiet) begin
            i_stall <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(0, 15);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        pos_m = 0;
        lo_m = 0;
        scale_m = 0;
        blk_m = 0;
        bpr_m = 11'd96;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_scales();
        test_row_lengths();
        test_random_stream();
        drain();
        repeat (10) @(posedge i_clk);
        if (fails == 0 && words_due.size() == 0)
            $display("q8_block_dequantizer_unit regression: pass");
        else
            $display("q8_block_dequantizer_unit regression: fail");
        $finish;
    end
endmodule
